// File: src/u8ar_pkg.sv
// Shared constants and the code point range check for the UTF-8 Arabic script detector.
// No dependencies; used by u8ar_decode and utf8_arabic_script_detector_unit.
`default_nettype none

package u8ar_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CpWidth   = 21;
   localparam int unsigned PendWidth = 2;

   // Lead byte classes: mask and the pattern that must match under it.
   localparam logic [7:0] Lead2Mask = 8'hE0;
   localparam logic [7:0] Lead2Code = 8'hC0;
   localparam logic [7:0] Lead3Mask = 8'hF0;
   localparam logic [7:0] Lead3Code = 8'hE0;
   localparam logic [7:0] Lead4Mask = 8'hF8;
   localparam logic [7:0] Lead4Code = 8'hF0;
   localparam logic [7:0] ContMask  = 8'h3F;

   localparam logic [CpWidth-1:0] ArabicLo   = 21'h000600;
   localparam logic [CpWidth-1:0] ArabicHi   = 21'h0006FF;
   localparam logic [CpWidth-1:0] SupplLo    = 21'h000750;
   localparam logic [CpWidth-1:0] SupplHi    = 21'h00077F;
   localparam logic [CpWidth-1:0] ExtALo     = 21'h0008A0;
   localparam logic [CpWidth-1:0] ExtAHi     = 21'h0008FF;
   localparam logic [CpWidth-1:0] PresALo    = 21'h00FB50;
   localparam logic [CpWidth-1:0] PresAHi    = 21'h00FDFF;
   localparam logic [CpWidth-1:0] PresBLo    = 21'h00FE70;
   localparam logic [CpWidth-1:0] PresBHi    = 21'h00FEFF;

   typedef struct packed {
      logic                 valid;
      logic [ByteWidth-1:0] text_byte;
      logic                 end_of_text;
   } step_type;

   function automatic logic is_arabic(input logic [CpWidth-1:0] cp);
      is_arabic = (cp >= ArabicLo && cp <= ArabicHi) ||
                  (cp >= SupplLo  && cp <= SupplHi)  ||
                  (cp >= ExtALo   && cp <= ExtAHi)   ||
                  (cp >= PresALo  && cp <= PresAHi)  ||
                  (cp >= PresBLo  && cp <= PresBHi);
   endfunction

endpackage

`default_nettype wire

// File: src/u8ar_decode.sv
// UTF-8 sequence assembler with the sticky Arabic range flag.
// Depends on u8ar_pkg for constants, the step struct and the range check.
`default_nettype none

module u8ar_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire u8ar_pkg::step_type step,
   output logic                   found
);

   logic [u8ar_pkg::PendWidth-1:0] pending_ff, pending_in;
   logic [u8ar_pkg::CpWidth-1:0]   acc_ff, acc_in;
   logic                           found_ff, found_in;
   logic [7:0]                     b;

   assign b = step.text_byte;

   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      found_in   = found_ff;
      if (pending_ff != '0) begin
         acc_in     = {acc_ff[u8ar_pkg::CpWidth-7:0], b[5:0] & u8ar_pkg::ContMask[5:0]};
         pending_in = pending_ff - 2'd1;
         if (pending_in == '0 && u8ar_pkg::is_arabic(acc_in)) begin
            found_in = 1'b1;
         end
      end else if ((b & u8ar_pkg::Lead2Mask) == u8ar_pkg::Lead2Code) begin
         acc_in     = {16'd0, b[4:0]};
         pending_in = 2'd1;
      end else if ((b & u8ar_pkg::Lead3Mask) == u8ar_pkg::Lead3Code) begin
         acc_in     = {17'd0, b[3:0]};
         pending_in = 2'd2;
      end else if ((b & u8ar_pkg::Lead4Mask) == u8ar_pkg::Lead4Code) begin
         acc_in     = {18'd0, b[2:0]};
         pending_in = 2'd3;
      end
   end

   // The flag as it stands after this byte; the top level registers it on the final byte.
   assign found = found_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         acc_ff     <= '0;
         found_ff   <= 1'b0;
      end else if (step.valid) begin
         if (step.end_of_text) begin
            // The final byte closes the text; a cut-short sequence is dropped here.
            pending_ff <= '0;
            acc_ff     <= '0;
            found_ff   <= 1'b0;
         end else begin
            pending_ff <= pending_in;
            acc_ff     <= acc_in;
            found_ff   <= found_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: src/utf8_arabic_script_detector_unit.sv
// Top level of the UTF-8 Arabic script detector: input register, decoder, result register.
// Depends on u8ar_pkg and u8ar_decode.
`default_nettype none

// Scans a UTF-8 text one byte per transaction on the req_ stream, with req_tlast on the
// final byte, and returns one rsp_ transaction per text whose bit 0 says whether any
// complete code point fell in an Arabic block. One byte is taken in every clock while no
// final byte waits in the input register. A byte passes from the input register through
// the combinational sequence assembler, and a final byte loads the result register from
// there. Only a final byte that meets a full, stalled result register waits in the input
// register, and the input stalls behind it.
module utf8_arabic_script_detector_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] text_byte
   input  wire logic       req_tlast,   // end_of_text
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] contains_arabic, [7:1] zero
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       s1_adv;
   logic       out_free;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_flag_ff;
   logic       found;
   u8ar_pkg::step_type step;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   // Bytes that give no result never wait on the output side.
   assign s1_adv     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_adv;

   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_adv);

   assign step.valid       = s1_adv;
   assign step.text_byte   = s1_byte_ff;
   assign step.end_of_text = s1_last_ff;

   u8ar_decode u_decode (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .found (found)
   );

   assign rsp_valid_in = (s1_adv && s1_last_ff) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_adv && s1_last_ff) begin
         rsp_flag_ff <= found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_flag_ff};

   a_rsp_from_final : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result appeared without a final byte in the input register");

   a_final_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> rsp_tvalid)
      else $error("final byte passed without loading a result");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_last_ff)))
      else $error("held byte lost while waiting on the result register");

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for utf8_arabic_script_detector_unit: UTF-8 texts go in on the req_ stream and
// each final byte's Arabic flag is predicted here and checked against the rsp_ stream.
// Depends on u8ar_pkg for the lead byte codes and on the unit itself.

module tb;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] text_byte
   logic       req_tlast = 1'b0;    // end_of_text
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b1;
   logic [7:0] rsp_tdata;           // [0] contains_arabic, [7:1] zero

   utf8_arabic_script_detector_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Arabic blocks, lowest first.
   logic [20:0] block_lo [0:4] = '{21'h000600, 21'h000750, 21'h0008A0, 21'h00FB50, 21'h00FE70};
   logic [20:0] block_hi [0:4] = '{21'h0006FF, 21'h00077F, 21'h0008FF, 21'h00FDFF, 21'h00FEFF};

   // Predictor state for the text in flight.
   logic [1:0]  utf_pending = 2'd0;
   logic [20:0] utf_code_point = 21'd0;
   logic        arabic_seen = 1'b0;
   logic        arabic_flags_expected [$];

   logic [7:0]  text_q [$];
   int          items_sent = 0;
   int          texts_sent = 0;
   int          fail_count = 0;
   int          cycle_count = 0;

   // Sender pacing and receiver stall control.
   bit          pacing_on = 1'b1;
   int          burst_left = 0;
   int          hold_request = 0;
   int          hold_left = 0;
   int          stall_mode = 0;
   int          stall_tick = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("utf8_arabic_script_detector_unit: mismatch");
         $finish;
      end
   end

   function automatic logic in_arabic_block(input logic [20:0] cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < 5; i++) begin
         if (cp >= block_lo[i] && cp <= block_hi[i]) hit = 1'b1;
      end
      return hit;
   endfunction

   // Advances the predictor by one accepted byte and queues the flag on a final byte.
   function automatic void predict_byte(input logic [7:0] b, input logic last);
      if (utf_pending != 2'd0) begin
         utf_code_point = {utf_code_point[14:0], b[5:0]};
         utf_pending = utf_pending - 2'd1;
         if (utf_pending == 2'd0 && in_arabic_block(utf_code_point)) arabic_seen = 1'b1;
      end else if ((b & u8ar_pkg::Lead2Mask) == u8ar_pkg::Lead2Code) begin
         utf_code_point = {16'd0, b[4:0]};
         utf_pending = 2'd1;
      end else if ((b & u8ar_pkg::Lead3Mask) == u8ar_pkg::Lead3Code) begin
         utf_code_point = {17'd0, b[3:0]};
         utf_pending = 2'd2;
      end else if ((b & u8ar_pkg::Lead4Mask) == u8ar_pkg::Lead4Code) begin
         utf_code_point = {18'd0, b[2:0]};
         utf_pending = 2'd3;
      end
      if (last) begin
         arabic_flags_expected.push_back(arabic_seen);
         utf_pending = 2'd0;
         utf_code_point = 21'd0;
         arabic_seen = 1'b0;
      end
   endfunction

   task automatic report_failure(input string what, input int expected_val, input int actual);
      fail_count++;
      if (fail_count <= 10)
         $display("%s: expected %0d, got %0d at cycle %0d", what, expected_val, actual,
                  cycle_count);
   endtask

   // Result checker and receiver stall pattern.
   always @(posedge clock) begin
      logic flag;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (arabic_flags_expected.size() == 0) begin
            report_failure("result with nothing pending, contains_arabic", -1,
                           int'(rsp_tdata[0]));
         end else begin
            flag = arabic_flags_expected.pop_front();
            if (rsp_tdata[0] !== flag)
               report_failure("contains_arabic", int'(flag), int'(rsp_tdata[0]));
            if (rsp_tdata[7:1] !== 7'd0)
               report_failure("rsp_tdata padding", 0, int'(rsp_tdata[7:1]));
         end
      end
      stall_tick++;
      if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (stall_tick % 5) != 0;
            default: rsp_tready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   // Offers one byte, waits for its transaction, then maybe idles before the next one.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, last);
      items_sent++;
      if (last) texts_sent++;
      if (pacing_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(0, 12);
         end
      end
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   // Holds the sender until every queued result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (arabic_flags_expected.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Encodes cp into n bytes and keeps the first keep of them; garble scrambles the
   // top two bits of every continuation byte.
   task automatic append_code_point(input logic [20:0] cp, input int n, input int keep,
                                    input bit garble);
      logic [7:0] enc [0:3];
      logic [7:0] cont;
      case (n)
         1: enc[0] = {1'b0, cp[6:0]};
         2: enc[0] = u8ar_pkg::Lead2Code | {3'd0, cp[10:6]};
         3: enc[0] = u8ar_pkg::Lead3Code | {4'd0, cp[15:12]};
         default: enc[0] = u8ar_pkg::Lead4Code | {5'd0, cp[20:18]};
      endcase
      for (int k = 1; k < n; k++) begin
         cont = {2'b10, 6'((cp >> (6 * (n - 1 - k))) & 21'h3F)};
         if (garble) cont[7:6] = 2'($urandom_range(0, 3));
         enc[k] = cont;
      end
      for (int k = 0; k < keep; k++) text_q.push_back(enc[k]);
   endtask

   function automatic logic [20:0] pick_code_point();
      int idx;
      int cp;
      case ($urandom_range(0, 3))
         0: begin
            idx = $urandom_range(0, 4);
            cp = ($urandom_range(0, 1) ? block_hi[idx] : block_lo[idx]);
            cp = cp + $urandom_range(0, 2) - 1;
         end
         1: begin
            idx = $urandom_range(0, 4);
            cp = $urandom_range(block_lo[idx], block_hi[idx]);
         end
         2: cp = $urandom_range(0, 16'hFFFF);
         default: cp = $urandom_range(0, 21'h1FFFFF);
      endcase
      return cp[20:0];
   endfunction

   task automatic append_random_unit();
      int sel;
      int n;
      logic [20:0] cp;
      sel = $urandom_range(0, 99);
      cp = pick_code_point();
      n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
      // Overlong forms still decode to the same value here.
      if (n < 4 && $urandom_range(0, 4) == 0) n = $urandom_range(n + 1, 4);
      if (sel < 15) begin
         text_q.push_back(8'($urandom_range(0, 127)));
      end else if (sel < 60) begin
         append_code_point(cp, n, n, 1'b0);
      end else if (sel < 70) begin
         append_code_point(21'($urandom_range(0, 21'h1FFFFF)), 4, 4, 1'b0);
      end else if (sel < 80) begin
         text_q.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 90) begin
         // Broken sequence: the next unit's bytes get swallowed as continuations.
         if (n < 2) n = 2;
         append_code_point(cp, n, $urandom_range(1, n - 1), 1'b0);
      end else begin
         if (n < 2) n = 2;
         append_code_point(cp, n, n, 1'b1);
      end
   endtask

   task automatic test_ascii_and_strays();
      text_q = '{8'h00, 8'h7F};
      send_text();
      // Stray continuation and invalid leads before a complete U+FEFF.
      text_q = '{8'h80, 8'hFF, 8'hF8, 8'hEF, 8'hBB, 8'hBF};
      send_text();
      text_q = '{8'hFF};
      send_text();
   endtask

   task automatic test_range_edges();
      // U+05FF and U+0700 sit just outside the first two blocks.
      text_q = '{8'hD7, 8'hBF, 8'hDC, 8'h80};
      send_text();
      text_q = '{8'hD8, 8'h80};
      send_text();
      // U+FB50 in an overlong four byte form.
      text_q = '{8'hF0, 8'h8F, 8'hAD, 8'h90};
      send_text();
   endtask

   task automatic test_malformed_and_cut();
      // A plain ASCII byte in continuation position still completes U+0600.
      text_q = '{8'hD8, 8'h00};
      send_text();
      // Texts that end inside a sequence.
      text_q = '{8'hEF, 8'hBB};
      send_text();
      text_q = '{8'hD8};
      send_text();
   endtask

   task automatic test_random_texts();
      int first_item;
      int first_text;
      int units;
      int n;
      first_item = items_sent;
      first_text = texts_sent;
      while (items_sent - first_item < 1020 || texts_sent - first_text < 48) begin
         if ($urandom_range(0, 7) == 0) pacing_on = !pacing_on;
         units = $urandom_range(1, 8);
         for (int u = 0; u < units; u++) append_random_unit();
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(2, 4);
            append_code_point(pick_code_point(), n, $urandom_range(1, n - 1), 1'b0);
         end
         send_text();
      end
      pacing_on = 1'b1;
   endtask

   // The receiver holds off while short texts keep coming, so the unit fills and stalls.
   task automatic test_result_backpressure();
      pacing_on = 1'b0;
      hold_request = 300;
      for (int t = 0; t < 40; t++) begin
         append_random_unit();
         send_text();
      end
      pacing_on = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_ascii_and_strays();
      drain();
      test_range_edges();
      drain();
      test_malformed_and_cut();
      drain();
      test_random_texts();
      drain();
      test_result_backpressure();
      drain();
      if (fail_count == 0) begin
         $display("utf8_arabic_script_detector_unit: match");
      end else begin
         $display("utf8_arabic_script_detector_unit: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
src/u8ar_pkg.sv
src/u8ar_decode.sv
src/utf8_arabic_script_detector_unit.sv
bench/tb.sv
